// ===== rtl/urgr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package urgr_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_GROW = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_ROWS   = 2'd0,
    CFG_COLS   = 2'd1,
    CFG_NODATA = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PASS,
    ST_CELL_RD,
    ST_CELL_CHK,
    ST_NB_RD,
    ST_NB_CHK,
    ST_NEXT,
    ST_READ,
    ST_DONE
  } state_t;

  localparam int CFG_W      = 24;
  localparam int RADIUS_MAX = 63;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int ELEV_BITS  = 24;

endpackage
`default_nettype wire

// ===== rtl/urgr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module urgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/upslope_region_grow_rings.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Upslope region grower. Loads, unused commands and addresses outside the
// rows/cols in use are taken one transaction per cycle while busy is low
// and answer in the cycle after acceptance; a read holds busy in ST_READ
// and answers in the cycle after it. A grow clears the mark memory in
// ST_CLEAR, marking the seed last, then runs passes. Pass p sets up in
// ST_PASS and walks rings 0..p around the seed (1 + 4p(p+1) positions):
// a position off the grid goes from ST_CELL_RD to ST_NEXT, an on-grid cell
// that cannot spread also passes ST_CELL_CHK, and a spreading cell then
// visits eight neighbors, through ST_NB_RD and ST_NB_CHK if on the grid and
// ST_NB_RD alone if not (one memory port each for elevations and marks).
// The first pass that marks nothing is followed by the closing state
// ST_DONE, and the answer comes in the cycle after it. busy stays high
// throughout; out_valid pulses once per transaction; it cannot be stalled.
module upslope_region_grow_rings
  import urgr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_command,
  input  wire logic [5:0]           in_row,
  input  wire logic [5:0]           in_col,
  input  wire logic signed [23:0]   in_elevation,
  output logic                      out_valid,
  output logic [5:0]                out_neighbor_size,
  output logic                      out_mark,
  output logic                      out_status,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int AB    = RB + CB;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int SB    = 13;

  state_t st_r, st_nxt;

  logic [6:0]                  rows_r, cols_r;
  logic signed [23:0]          nodata_r;
  logic signed [12:0]          rows_eff, cols_eff;

  logic signed [SB-1:0]        sr_r, sc_r, cr_r, cc_r, nr_r, nc_r;
  logic [SB-1:0]               d_r, lim_r, x_r;
  logic [1:0]                  side_r;
  logic [2:0]                  k_r;
  logic [6:0]                  rad_r;
  logic                        found_r;
  logic [AB:0]                 clr_r;
  logic signed [ELEV_BITS-1:0] v_r;
  logic [5:0]                  res_ns_r;
  logic                        res_mark_r, res_st_r, res_v_r;
  logic                        grown_r;

  logic                        e_we, m_we, m_wd;
  logic [AB-1:0]               e_wa, e_ra, m_wa, m_ra;
  logic [ELEV_BITS-1:0]        e_wd, e_rd;
  logic                        m_rd;

  urgr_ram #(.WIDTH(ELEV_BITS), .DEPTH(CELLS)) u_elev (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
  );
  urgr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mark (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
  );

  always_comb begin
    rows_eff = (rows_r > 7'(MAX_ROWS > 127 ? 127 : MAX_ROWS))
             ? 13'(MAX_ROWS) : 13'(rows_r);
    cols_eff = (cols_r > 7'(MAX_COLS > 127 ? 127 : MAX_COLS))
             ? 13'(MAX_COLS) : 13'(cols_r);
    if (MAX_ROWS > 127) rows_eff = 13'(rows_r);
    if (MAX_COLS > 127) cols_eff = 13'(cols_r);
  end

  function automatic logic in_g(input logic signed [SB-1:0] r, input logic signed [SB-1:0] c,
                                input logic signed [12:0] re, input logic signed [12:0] ce);
    in_g = (r >= 0) && (r < re) && (c >= 0) && (c < ce);
  endfunction

  logic signed [ELEV_BITS-1:0] nod;
  assign nod = ELEV_BITS'(nodata_r);

  logic accept, addr_ok;
  assign busy    = (st_r != ST_IDLE);
  assign accept  = start && !busy;
  assign addr_ok = in_g(SB'(in_row), SB'(in_col), rows_eff, cols_eff);

  // scan position: current ring cell from (side, x)
  logic signed [SB-1:0] pr, pc, ds;
  always_comb begin
    ds = d_r;
    case (side_r)
      2'd0: begin pr = sr_r - ds; pc = sc_r + x_r; end
      2'd1: begin pr = sr_r + x_r; pc = sc_r + ds; end
      2'd2: begin pr = sr_r + ds; pc = sc_r + x_r; end
      default: begin pr = sr_r + x_r; pc = sc_r - ds; end
    endcase
  end

  // end-of-ring-walk detection for ST_NEXT
  logic last_cell, last_ring;
  always_comb begin
    last_cell = (d_r == 0) || (side_r == 2'd3 && x_r == SB'(-$signed(d_r) + 1));
    last_ring = (d_r == lim_r);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:     if (accept && addr_ok && in_command == CMD_GROW) st_nxt = ST_CLEAR;
                   else if (accept && addr_ok && in_command == CMD_READ) st_nxt = ST_READ;
      ST_READ:     st_nxt = ST_IDLE;
      ST_CLEAR:    if (clr_r == (AB+1)'(CELLS)) st_nxt = ST_PASS;
      ST_PASS:     st_nxt = ST_CELL_RD;
      ST_CELL_RD:  st_nxt = in_g(pr, pc, rows_eff, cols_eff) ? ST_CELL_CHK : ST_NEXT;
      ST_CELL_CHK: st_nxt = (e_rd != nod && m_rd) ? ST_NB_RD : ST_NEXT;
      ST_NB_RD:    st_nxt = in_g(nr_r, nc_r, rows_eff, cols_eff) ? ST_NB_CHK : ST_NEXT;
      ST_NB_CHK:   st_nxt = ST_NB_RD;
      ST_NEXT:     st_nxt = (last_cell && last_ring) ? (found_r ? ST_PASS : ST_DONE)
                                                     : ST_CELL_RD;
      ST_DONE:     st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
    if (st_r == ST_NB_RD && k_r == 3'd7 && !in_g(nr_r, nc_r, rows_eff, cols_eff))
      st_nxt = ST_NEXT;
    if (st_r == ST_NB_CHK && k_r == 3'd7) st_nxt = ST_NEXT;
    if (st_r == ST_NB_RD && k_r != 3'd7 && !in_g(nr_r, nc_r, rows_eff, cols_eff))
      st_nxt = ST_NB_RD;
  end

  always_comb begin
    e_we = 1'b0; e_wa = {RB'(in_row), CB'(in_col)}; e_wd = ELEV_BITS'(in_elevation);
    m_we = 1'b0; m_wa = '0; m_wd = 1'b0;
    e_ra = {RB'(pr), CB'(pc)}; m_ra = {RB'(pr), CB'(pc)};
    if (accept && addr_ok && in_command == CMD_LOAD) e_we = 1'b1;
    if (st_r == ST_IDLE) m_ra = {RB'(in_row), CB'(in_col)};
    if (st_r == ST_NB_RD || st_r == ST_NB_CHK) begin
      e_ra = {RB'(nr_r), CB'(nc_r)}; m_ra = {RB'(nr_r), CB'(nc_r)};
    end
    if (st_r == ST_CLEAR) begin
      m_we = (clr_r < (AB+1)'(CELLS));
      m_wa = AB'(clr_r);
      if (clr_r == (AB+1)'(CELLS)) begin
        m_we = 1'b1; m_wd = 1'b1; m_wa = {RB'(sr_r), CB'(sc_r)};
      end
    end
    if (st_r == ST_NB_CHK && e_rd != nod && $signed(e_rd) > v_r && !m_rd) begin
      m_we = 1'b1; m_wd = 1'b1; m_wa = {RB'(nr_r), CB'(nc_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; rows_r <= 7'd64; cols_r <= 7'd64; nodata_r <= -24'sd9999;
      res_v_r <= 1'b0; grown_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS:   rows_r <= cfg_data[6:0];
          CFG_COLS:   cols_r <= cfg_data[6:0];
          CFG_NODATA: nodata_r <= cfg_data[23:0];
          default: ;
        endcase
      end
      res_v_r <= (accept && !(addr_ok && in_command inside {CMD_GROW, CMD_READ}))
              || (st_r == ST_READ) || (st_r == ST_DONE);
      if (accept) begin
        res_ns_r <= '0; res_mark_r <= 1'b0;
        res_st_r <= (in_command != CMD_NONE) && !addr_ok;
        sr_r <= SB'(in_row); sc_r <= SB'(in_col);
        clr_r <= '0; rad_r <= '0;
      end
      if (st_r == ST_READ) res_mark_r <= m_rd & grown_r;
      if (st_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
        grown_r <= 1'b1;
      end
      if (st_r == ST_PASS) begin
        d_r <= '0; side_r <= '0; x_r <= '0; found_r <= 1'b0;
        lim_r <= SB'(rad_r);
      end
      if (st_r == ST_CELL_RD) begin cr_r <= pr; cc_r <= pc; end
      if (st_r == ST_CELL_CHK) begin
        v_r <= e_rd; k_r <= '0; nr_r <= cr_r - 13'sd1; nc_r <= cc_r - 13'sd1;
      end
      if (st_r == ST_NB_RD && !in_g(nr_r, nc_r, rows_eff, cols_eff) && k_r != 3'd7) begin
        k_r <= k_r + 1'b1;
      end
      if (st_r == ST_NB_CHK) begin
        if (m_we) found_r <= 1'b1;
        k_r <= k_r + 1'b1;
      end
      if ((st_r == ST_NB_CHK) ||
          (st_r == ST_NB_RD && !in_g(nr_r, nc_r, rows_eff, cols_eff) && k_r != 3'd7)) begin
        case (k_r + 3'd1)
          3'd1: begin nr_r <= cr_r - 13'sd1; nc_r <= cc_r;          end
          3'd2: begin nr_r <= cr_r - 13'sd1; nc_r <= cc_r + 13'sd1; end
          3'd3: begin nr_r <= cr_r;          nc_r <= cc_r - 13'sd1; end
          3'd4: begin nr_r <= cr_r;          nc_r <= cc_r + 13'sd1; end
          3'd5: begin nr_r <= cr_r + 13'sd1; nc_r <= cc_r - 13'sd1; end
          3'd6: begin nr_r <= cr_r + 13'sd1; nc_r <= cc_r;          end
          default: begin nr_r <= cr_r + 13'sd1; nc_r <= cc_r + 13'sd1; end
        endcase
      end
      if (st_r == ST_NEXT) begin
        if (last_cell) begin
          if (last_ring) begin
            if (found_r) begin
              if (rad_r != 7'd127) rad_r <= rad_r + 1'b1;
            end else begin
              res_ns_r <= (rad_r > 7'(RADIUS_MAX)) ? 6'(RADIUS_MAX) : rad_r[5:0];
            end
          end else begin
            d_r <= d_r + 1'b1; side_r <= 2'd0; x_r <= SB'(-$signed(d_r + 1'b1));
          end
        end else begin
          case (side_r)
            2'd0: if (x_r == d_r) begin side_r <= 2'd1; x_r <= SB'(-$signed(d_r) + 1); end
                  else x_r <= x_r + 1'b1;
            2'd1: if (x_r == d_r - 1'b1) begin side_r <= 2'd2; x_r <= d_r; end
                  else x_r <= x_r + 1'b1;
            2'd2: if (x_r == SB'(-$signed(d_r))) begin side_r <= 2'd3; x_r <= d_r - 1'b1; end
                  else x_r <= x_r - 1'b1;
            default: x_r <= x_r - 1'b1;
          endcase
        end
      end
    end
  end

  assign out_valid         = res_v_r;
  assign out_neighbor_size = res_ns_r;
  assign out_mark          = res_mark_r;
  assign out_status        = res_st_r;

endmodule
`default_nettype wire
